[design/text_console_cell_writer_unit_macros.svh]
// Assertion macros for the checker file of the text console.
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define TCCW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define TCCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/tccw_pkg.sv]
`default_nettype none

package tccw_pkg;

  // Default screen geometry.
  localparam int unsigned SCREEN_ROWS_DEF = 25;
  localparam int unsigned SCREEN_COLS_DEF = 80;

  // Cell layout and special characters.
  localparam int unsigned CELL_W       = 16;
  localparam logic [7:0]  DEFAULT_ATTR = 8'h07;
  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_PUT_CHAR   = 2'd0,
    CMD_CLEAR      = 2'd1,
    CMD_SET_CURSOR = 2'd2,
    CMD_READ_CELL  = 2'd3
  } cmd_t;

  // One command transaction.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] char_code;
    logic [4:0] target_row;
    logic [6:0] target_col;
  } cmd_item_t;

  // One response transaction.
  typedef struct packed {
    logic [4:0]        cursor_row_out;
    logic [6:0]        cursor_col_out;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } rsp_item_t;

  // A cell holds the attribute in the high byte and the character in the low byte.
  function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] attr,
                                                   input logic [7:0] ch);
    make_cell = {attr, ch};
  endfunction

endpackage

`default_nettype wire

[design/text_console_cell_writer_unit.sv]
// From acceptance to the response register: set cursor goes straight to the done state,
// put char passes the put state, the new-row state or both, read cell the read and
// read-wait states; a scroll or a clear adds one pass over the screen store through its
// single write port. Commands are taken one at a time, the next once the response loads.
// Reset: synchronous, clears the cursor and the attribute register (to 0x07), then a
// clearing pass over every cell zeroes the store while no command is accepted.
`default_nettype none

module text_console_cell_writer_unit
  import tccw_pkg::*;
#(
  parameter int unsigned SCREEN_ROWS = SCREEN_ROWS_DEF,
  parameter int unsigned SCREEN_COLS = SCREEN_COLS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire cmd_item_t  cmd_item,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output rsp_item_t       rsp_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  localparam int unsigned CELLS  = SCREEN_ROWS * SCREEN_COLS;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  logic [7:0]        attr;
  logic              res_valid;
  logic              res_ready;
  rsp_item_t         res_item;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;

  // Attribute register; a write is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= DEFAULT_ATTR;
    end else if (cfg_valid) begin
      attr <= cfg_data;
    end
  end

  // Response register between the sequencer and the output channel.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp_item <= res_item;
    end
  end

  tccw_ctrl #(
    .SCREEN_ROWS(SCREEN_ROWS),
    .SCREEN_COLS(SCREEN_COLS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .attr     (attr),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_item (cmd_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item (res_item),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  tccw_screen_ram #(
    .DEPTH(CELLS)
  ) u_screen_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

`default_nettype wire

[design/tccw_screen_ram.sv]
`default_nettype none

module tccw_screen_ram
  import tccw_pkg::*;
#(
  parameter int unsigned DEPTH = SCREEN_ROWS_DEF * SCREEN_COLS_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/tccw_ctrl.sv]
`default_nettype none

module tccw_ctrl
  import tccw_pkg::*;
#(
  parameter int unsigned SCREEN_ROWS = SCREEN_ROWS_DEF,
  parameter int unsigned SCREEN_COLS = SCREEN_COLS_DEF,
  localparam int unsigned ADDR_W = $clog2(SCREEN_ROWS * SCREEN_COLS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        attr,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire cmd_item_t         cmd_item,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output rsp_item_t              res_item,
  output logic                   we,
  output logic      [ADDR_W-1:0] waddr,
  output logic      [CELL_W-1:0] wdata,
  output logic                   re,
  output logic      [ADDR_W-1:0] raddr,
  input  wire logic [CELL_W-1:0] rdata
);

  localparam int unsigned CELLS         = SCREEN_ROWS * SCREEN_COLS;
  localparam int unsigned ROW_W         = $clog2(SCREEN_ROWS);
  localparam int unsigned COL_W         = $clog2(SCREEN_COLS);
  localparam int unsigned LAST_ROW_BASE = (SCREEN_ROWS - 1) * SCREEN_COLS;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_NEWROW,
    S_READ,
    S_RWAIT,
    S_SCROLL,
    S_DRAIN,
    S_BLANK,
    S_DONE
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] sweep;
  logic              copy_vld;
  logic [ADDR_W-1:0] copy_addr;
  logic [ROW_W-1:0]  crow;
  logic [COL_W-1:0]  ccol;
  logic [ROW_W-1:0]  trow;
  logic [COL_W-1:0]  tcol;
  logic [7:0]        cur_char;
  logic [CELL_W-1:0] cell_data;
  logic              scrolled;

  logic [ROW_W-1:0]  trow_in;
  logic [COL_W-1:0]  tcol_in;
  logic [ROW_W-1:0]  au_row;
  logic [COL_W-1:0]  au_col;
  logic [ADDR_W-1:0] au_addr;
  logic [ADDR_W-1:0] sweep_inc;
  logic              sweep_last;

  // Saturate the requested position to the screen bounds.
  always_comb begin
    if (32'(cmd_item.target_row) >= SCREEN_ROWS) begin
      trow_in = ROW_W'(SCREEN_ROWS - 1);
    end else begin
      trow_in = ROW_W'(cmd_item.target_row);
    end
    if (32'(cmd_item.target_col) >= SCREEN_COLS) begin
      tcol_in = COL_W'(SCREEN_COLS - 1);
    end else begin
      tcol_in = COL_W'(cmd_item.target_col);
    end
  end

  // Shared address unit: a cell address from a row and a column, and the sweep step.
  assign au_row     = (state == S_READ) ? trow : crow;
  assign au_col     = (state == S_READ) ? tcol : ccol;
  assign au_addr    = ADDR_W'(32'(au_row) * SCREEN_COLS + 32'(au_col));
  assign sweep_inc  = sweep + ADDR_W'(1);
  assign sweep_last = (sweep == ADDR_W'(CELLS - 1));

  // Screen store port selection. A scroll copy writes in the cycle after its read.
  always_comb begin
    we    = 1'b0;
    waddr = sweep;
    wdata = '0;
    re    = 1'b0;
    raddr = sweep;
    case (state)
      S_INIT: begin
        we = 1'b1;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = au_addr;
        wdata = make_cell(attr, cur_char);
      end
      S_READ: begin
        re    = 1'b1;
        raddr = au_addr;
      end
      S_SCROLL: begin
        re = 1'b1;
      end
      S_BLANK: begin
        we    = 1'b1;
        wdata = make_cell(attr, SPACE_CODE);
      end
      default: begin
      end
    endcase
    if (copy_vld) begin
      we    = 1'b1;
      waddr = copy_addr;
      wdata = rdata;
    end
  end

  assign cmd_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res_item.cursor_row_out = 5'(crow);
    res_item.cursor_col_out = 7'(ccol);
    res_item.cell_value     = cell_data;
    res_item.scrolled       = scrolled;
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      sweep    <= '0;
      copy_vld <= 1'b0;
      crow     <= '0;
      ccol     <= '0;
      scrolled <= 1'b0;
    end else begin
      copy_vld  <= (state == S_SCROLL);
      copy_addr <= ADDR_W'(32'(sweep) - SCREEN_COLS);
      case (state)
        S_INIT: begin
          sweep <= sweep_inc;
          if (sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cell_data <= '0;
            scrolled  <= 1'b0;
            cur_char  <= cmd_item.char_code;
            trow      <= trow_in;
            tcol      <= tcol_in;
            case (cmd_item.cmd)
              CMD_PUT_CHAR: begin
                if (cmd_item.char_code == NEWLINE_CODE) begin
                  state <= S_NEWROW;
                end else begin
                  state <= S_PUT;
                end
              end
              CMD_CLEAR: begin
                crow  <= '0;
                ccol  <= '0;
                sweep <= '0;
                state <= S_BLANK;
              end
              CMD_SET_CURSOR: begin
                crow  <= trow_in;
                ccol  <= tcol_in;
                state <= S_DONE;
              end
              CMD_READ_CELL: begin
                state <= S_READ;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PUT: begin
          if (ccol == COL_W'(SCREEN_COLS - 1)) begin
            state <= S_NEWROW;
          end else begin
            ccol  <= ccol + COL_W'(1);
            state <= S_DONE;
          end
        end
        S_NEWROW: begin
          ccol <= '0;
          if (crow == ROW_W'(SCREEN_ROWS - 1)) begin
            scrolled <= 1'b1;
            sweep    <= ADDR_W'(SCREEN_COLS);
            state    <= S_SCROLL;
          end else begin
            crow  <= crow + ROW_W'(1);
            state <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          cell_data <= rdata;
          state     <= S_DONE;
        end
        S_SCROLL: begin
          sweep <= sweep_inc;
          if (sweep_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          sweep <= ADDR_W'(LAST_ROW_BASE);
          state <= S_BLANK;
        end
        S_BLANK: begin
          sweep <= sweep_inc;
          if (sweep_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/tccw_checker.sv]
`default_nettype none
`include "text_console_cell_writer_unit_macros.svh"

module tccw_checker
  import tccw_pkg::*;
#(
  parameter int unsigned SCREEN_ROWS = SCREEN_ROWS_DEF,
  parameter int unsigned SCREEN_COLS = SCREEN_COLS_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      cmd_valid,
  input wire logic      cmd_ready,
  input wire logic      rsp_valid,
  input wire rsp_item_t rsp_item
);

  // The clearing pass keeps commands out right after reset.
  `TCCW_ASSERT_ALWAYS(a_busy_after_reset, clk, rst |=> !cmd_ready, "ready right after reset")

  // Commands are worked on one at a time.
  `TCCW_ASSERT(a_one_at_a_time, clk, rst, cmd_valid && cmd_ready |=> !cmd_ready, "ready twice in a row")

  // A scroll always leaves the cursor at the start of the last row.
  `TCCW_ASSERT(a_scroll_cursor, clk, rst, rsp_valid && rsp_item.scrolled |-> rsp_item.cursor_col_out == 7'd0 && rsp_item.cursor_row_out == 5'(SCREEN_ROWS - 1), "scroll left cursor elsewhere")

  // The reported cursor stays on the screen.
  `TCCW_ASSERT(a_cursor_bounds, clk, rst, rsp_valid |-> 32'(rsp_item.cursor_row_out) < SCREEN_ROWS && 32'(rsp_item.cursor_col_out) < SCREEN_COLS, "cursor off screen")

endmodule

bind text_console_cell_writer_unit tccw_checker #(
  .SCREEN_ROWS(SCREEN_ROWS),
  .SCREEN_COLS(SCREEN_COLS)
) u_tccw_checker (
  .clk      (clk),
  .rst      (rst),
  .cmd_valid(cmd_valid),
  .cmd_ready(cmd_ready),
  .rsp_valid(rsp_valid),
  .rsp_item (rsp_item)
);

`default_nettype wire
